@@ rtl/sst_pkg.sv @@
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types, character codes and helpers of the shader source tokenizer.
// ----------------------------------------------------------------------------
package sst_pkg;

  // Sizes
  localparam int TEXT_CAPACITY_DEF = 32;   // default text buffer depth
  localparam int TEXT_LIMIT        = 32;   // most text bytes a token reports
  localparam int KIND_W            = 4;
  localparam int LEN_W             = 6;
  localparam int IDX_W             = 5;
  localparam int MANT_W            = 63;
  localparam int FRAC_W            = 5;

  localparam logic [MANT_W-1:0] MANT_MAX = {MANT_W{1'b1}};
  localparam logic [FRAC_W-1:0] FRAC_MAX = {FRAC_W{1'b1}};

  // Character codes
  localparam logic [7:0] CH_SPACE_MAX = 8'd32;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_0         = 8'h30;
  localparam logic [7:0] CH_9         = 8'h39;
  localparam logic [7:0] CH_LOWER_A   = 8'h61;
  localparam logic [7:0] CH_LOWER_Z   = 8'h7A;
  localparam logic [7:0] CH_UPPER_A   = 8'h41;
  localparam logic [7:0] CH_UPPER_Z   = 8'h5A;

  // Keyword lengths
  localparam logic [LEN_W-1:0] KW_UNIFORM_LEN = 6'd7;
  localparam logic [LEN_W-1:0] KW_IN_LEN      = 6'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_NAME    = 4'd0,
    KIND_LPAREN  = 4'd1,
    KIND_RPAREN  = 4'd2,
    KIND_LBRACE  = 4'd3,
    KIND_RBRACE  = 4'd4,
    KIND_LITERAL = 4'd5,
    KIND_STRING  = 4'd6,
    KIND_ERROR   = 4'd7,
    KIND_END     = 4'd8
  } token_kind_e;

  // Input word
  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_input;
  } in_word_t;

  // Output word
  typedef struct packed {
    logic [KIND_W-1:0] token_kind;
    logic [7:0]        text_byte;
    logic [IDX_W-1:0]  text_index;
    logic [LEN_W-1:0]  token_length;
    logic              run_last;
    logic [MANT_W-1:0] literal_mantissa;
    logic [FRAC_W-1:0] fraction_digits;
    logic              is_uniform;
    logic              is_in;
    logic              overflow;
    logic              unterminated;
  } out_word_t;

  // Work handed from the scanner to the emitter for one accepted word
  typedef struct packed {
    logic              flush_valid;   // a pending token ends
    token_kind_e       flush_kind;
    logic [LEN_W-1:0]  flush_len;     // stored text bytes, 0 for literals
    logic              flush_ovf;
    logic              flush_unt;
    logic [MANT_W-1:0] flush_mant;
    logic [FRAC_W-1:0] flush_frac;
    logic              single_valid;  // one-result token after the flush
    token_kind_e       single_kind;
    logic [7:0]        single_byte;
  } cmd_t;

  function automatic logic is_alpha(logic [7:0] b);
    return (b >= CH_LOWER_A && b <= CH_LOWER_Z) ||
           (b >= CH_UPPER_A && b <= CH_UPPER_Z) || (b == CH_UNDERSCORE);
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return (b >= CH_0) && (b <= CH_9);
  endfunction

  // Byte b matches "uniform" at position idx
  function automatic logic uniform_match(logic [IDX_W-1:0] idx, logic [7:0] b);
    logic hit;
    unique case (idx)
      5'd0:    hit = (b == "u");
      5'd1:    hit = (b == "n");
      5'd2:    hit = (b == "i");
      5'd3:    hit = (b == "f");
      5'd4:    hit = (b == "o");
      5'd5:    hit = (b == "r");
      5'd6:    hit = (b == "m");
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // Byte b matches "in" at position idx
  function automatic logic in_match(logic [IDX_W-1:0] idx, logic [7:0] b);
    logic hit;
    unique case (idx)
      5'd0:    hit = (b == "i");
      5'd1:    hit = (b == "n");
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

@@ rtl/sst_in_if.sv @@
// ----------------------------------------------------------------------------
// sst_in_if
// Valid/ready channel carrying source words into the tokenizer.
// ----------------------------------------------------------------------------
interface sst_in_if;
  logic              valid;
  logic              ready;
  sst_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/sst_out_if.sv @@
// ----------------------------------------------------------------------------
// sst_out_if
// Valid/ready channel carrying token result words out of the tokenizer.
// ----------------------------------------------------------------------------
interface sst_out_if;
  logic               valid;
  logic               ready;
  sst_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/sst_scan.sv @@
// ----------------------------------------------------------------------------
// sst_scan
// Scanner: classifies each accepted byte, tracks the token in progress,
// builds the literal mantissa and appends name/string text to the buffer.
// ----------------------------------------------------------------------------
module sst_scan #(
  parameter int TEXT_CAPACITY = sst_pkg::TEXT_CAPACITY_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  sst_pkg::in_word_t     word_i,
  output sst_pkg::cmd_t         cmd_o,
  output logic                  wr_en_o,
  output logic [$clog2((TEXT_CAPACITY < sst_pkg::TEXT_LIMIT) ? TEXT_CAPACITY
                       : sst_pkg::TEXT_LIMIT)-1:0] wr_addr_o,
  output logic [7:0]            wr_data_o,
  output logic                  scan_idle_o
);

  localparam int STORE_LIMIT = (TEXT_CAPACITY < sst_pkg::TEXT_LIMIT) ?
                               TEXT_CAPACITY : sst_pkg::TEXT_LIMIT;
  localparam int AW = $clog2(STORE_LIMIT);
  localparam int CW = $clog2(STORE_LIMIT + 1);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_NAME,
    MODE_LIT,
    MODE_STR
  } mode_e;

  mode_e                      mode_q, mode_d;
  logic [CW-1:0]              count_q, count_d;
  logic [sst_pkg::MANT_W-1:0] mant_q, mant_d;
  logic                       dot_q, dot_d;
  logic [sst_pkg::FRAC_W-1:0] frac_q, frac_d;
  logic                       ovf_q, ovf_d;

  logic [7:0]                 b;
  logic [3:0]                 digit;
  logic [sst_pkg::MANT_W+3:0] prod;
  logic                       alpha, numeric;
  logic                       flush, go_idle, append;
  logic                       wr_en;
  sst_pkg::cmd_t              cmd;

  assign b       = word_i.source_byte;
  assign digit   = 4'(b - sst_pkg::CH_0);
  assign alpha   = sst_pkg::is_alpha(b);
  assign numeric = sst_pkg::is_digit(b);

  // mantissa * 10 + digit as shift-add, four guard bits catch overflow
  assign prod = ({4'b0, mant_q} << 3) + ({4'b0, mant_q} << 1) +
                {{(sst_pkg::MANT_W){1'b0}}, digit};

  // Next token state and work for the emitter
  always_comb begin
    mode_d    = mode_q;
    count_d   = count_q;
    mant_d    = mant_q;
    dot_d     = dot_q;
    frac_d    = frac_q;
    ovf_d     = ovf_q;
    flush     = 1'b0;
    go_idle   = 1'b0;
    append    = 1'b0;
    cmd       = '0;
    wr_en     = 1'b0;
    wr_addr_o = count_q[AW-1:0];

    if (word_i.end_of_input) begin
      flush            = (mode_q != MODE_IDLE);
      cmd.single_valid = 1'b1;
      cmd.single_kind  = sst_pkg::KIND_END;
    end else begin
      unique case (mode_q)
        MODE_NAME: begin
          if (alpha || numeric) append = 1'b1;
          else begin
            flush   = 1'b1;
            go_idle = 1'b1;
          end
        end
        MODE_LIT: begin
          if (numeric) begin
            if (|prod[sst_pkg::MANT_W+3:sst_pkg::MANT_W]) begin
              mant_d = sst_pkg::MANT_MAX;
              ovf_d  = 1'b1;
            end else begin
              mant_d = prod[sst_pkg::MANT_W-1:0];
            end
            if (dot_q && frac_q != sst_pkg::FRAC_MAX) frac_d = frac_q + 1'b1;
          end else if (b == sst_pkg::CH_DOT && !dot_q) begin
            dot_d = 1'b1;
          end else begin
            flush   = 1'b1;
            go_idle = 1'b1;
          end
        end
        MODE_STR: begin
          if (b == sst_pkg::CH_QUOTE) flush = 1'b1;
          else append = 1'b1;
        end
        default: go_idle = 1'b1;
      endcase
    end

    // text append, dropped and flagged once the buffer is full
    if (append) begin
      if (count_q < CW'(STORE_LIMIT)) begin
        wr_en   = 1'b1;
        count_d = count_q + 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
    end

    // pending token ends: hand over its summary and start clean
    if (flush || word_i.end_of_input) begin
      cmd.flush_valid = flush;
      cmd.flush_ovf   = ovf_q;
      cmd.flush_unt   = (mode_q == MODE_STR) && word_i.end_of_input;
      unique case (mode_q)
        MODE_LIT: begin
          cmd.flush_kind = sst_pkg::KIND_LITERAL;
          cmd.flush_mant = mant_q;
          cmd.flush_frac = frac_q;
        end
        MODE_STR: begin
          cmd.flush_kind = sst_pkg::KIND_STRING;
          cmd.flush_len  = sst_pkg::LEN_W'(count_q);
        end
        default: begin
          cmd.flush_kind = sst_pkg::KIND_NAME;
          cmd.flush_len  = sst_pkg::LEN_W'(count_q);
        end
      endcase
      mode_d  = MODE_IDLE;
      count_d = '0;
      mant_d  = '0;
      dot_d   = 1'b0;
      frac_d  = '0;
      ovf_d   = 1'b0;
    end

    // byte seen between tokens
    if (go_idle) begin
      priority if (b <= sst_pkg::CH_SPACE_MAX) begin
        mode_d = MODE_IDLE;
      end else if (alpha) begin
        mode_d    = MODE_NAME;
        wr_en     = 1'b1;
        wr_addr_o = '0;
        count_d   = CW'(1);
      end else if (numeric) begin
        mode_d = MODE_LIT;
        mant_d = {{(sst_pkg::MANT_W-4){1'b0}}, digit};
      end else if (b == sst_pkg::CH_QUOTE) begin
        mode_d = MODE_STR;
      end else if (b == sst_pkg::CH_LPAREN) begin
        cmd.single_valid = 1'b1;
        cmd.single_kind  = sst_pkg::KIND_LPAREN;
      end else if (b == sst_pkg::CH_RPAREN) begin
        cmd.single_valid = 1'b1;
        cmd.single_kind  = sst_pkg::KIND_RPAREN;
      end else if (b == sst_pkg::CH_LBRACE) begin
        cmd.single_valid = 1'b1;
        cmd.single_kind  = sst_pkg::KIND_LBRACE;
      end else if (b == sst_pkg::CH_RBRACE) begin
        cmd.single_valid = 1'b1;
        cmd.single_kind  = sst_pkg::KIND_RBRACE;
      end else begin
        cmd.single_valid = 1'b1;
        cmd.single_kind  = sst_pkg::KIND_ERROR;
        cmd.single_byte  = b;
      end
    end
  end

  // text lands in memory only on an accepted word
  assign wr_en_o     = wr_en && accept_i;
  assign cmd_o       = cmd;
  assign wr_data_o   = b;
  assign scan_idle_o = (mode_q == MODE_IDLE);

  // Token state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      count_q <= '0;
      mant_q  <= '0;
      dot_q   <= 1'b0;
      frac_q  <= '0;
      ovf_q   <= 1'b0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      count_q <= count_d;
      mant_q  <= mant_d;
      dot_q   <= dot_d;
      frac_q  <= frac_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

@@ rtl/sst_emit.sv @@
// ----------------------------------------------------------------------------
// sst_emit
// Emitter: owns the token text memory and walks a finished token out of it,
// one result word per stored byte, into the output register.
// ----------------------------------------------------------------------------
module sst_emit #(
  parameter int TEXT_CAPACITY = sst_pkg::TEXT_CAPACITY_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  sst_pkg::cmd_t         cmd_i,
  input  logic                  wr_en_i,
  input  logic [$clog2((TEXT_CAPACITY < sst_pkg::TEXT_LIMIT) ? TEXT_CAPACITY
                       : sst_pkg::TEXT_LIMIT)-1:0] wr_addr_i,
  input  logic [7:0]            wr_data_i,
  output logic                  ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output sst_pkg::out_word_t    out_data_o
);

  localparam int STORE_LIMIT = (TEXT_CAPACITY < sst_pkg::TEXT_LIMIT) ?
                               TEXT_CAPACITY : sst_pkg::TEXT_LIMIT;
  localparam int AW = $clog2(STORE_LIMIT);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_FETCH
  } state_e;

  state_e             state_q, state_d;
  sst_pkg::cmd_t      job_q, job_d;
  logic [AW-1:0]      idx_q, idx_d;
  logic               kw_uni_q, kw_uni_d;
  logic               kw_in_q, kw_in_d;
  logic               out_valid_q, out_valid_d;
  sst_pkg::out_word_t out_data_q, out_data_d;

  logic [7:0]                 text_mem_q [STORE_LIMIT];
  logic [7:0]                 rd_data_q;
  logic                       rd_en;
  logic                       can_load;
  logic                       text_job;
  logic                       last;
  logic                       u_hit, i_hit;
  logic [sst_pkg::IDX_W-1:0]  idx_ext;

  // Text memory: writes come only while idle, reads only while emitting,
  // so the two never touch the same entry in one cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) text_mem_q[wr_addr_i] <= wr_data_i;
    if (rd_en)   rd_data_q <= text_mem_q[idx_q];
  end

  assign can_load = !out_valid_q || out_ready_i;
  assign text_job = job_q.flush_valid && (job_q.flush_len != '0);
  assign idx_ext  = sst_pkg::IDX_W'(idx_q);
  assign last     = (sst_pkg::LEN_W'(idx_q) + 1'b1) == job_q.flush_len;
  assign u_hit    = sst_pkg::uniform_match(idx_ext, rd_data_q);
  assign i_hit    = sst_pkg::in_match(idx_ext, rd_data_q);

  // Sequencer: flush run first, then the one-result token
  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    idx_d       = idx_q;
    kw_uni_d    = kw_uni_q;
    kw_in_d     = kw_in_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    rd_en       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          job_d    = cmd_i;
          idx_d    = '0;
          kw_uni_d = 1'b1;
          kw_in_d  = 1'b1;
          if (cmd_i.flush_valid || cmd_i.single_valid) state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        priority if (text_job) begin
          rd_en   = 1'b1;
          state_d = ST_FETCH;
        end else if (job_q.flush_valid) begin
          // token without text: one word with its summary
          if (can_load) begin
            out_valid_d                  = 1'b1;
            out_data_d                   = '0;
            out_data_d.token_kind        = job_q.flush_kind;
            out_data_d.run_last          = 1'b1;
            out_data_d.literal_mantissa  = job_q.flush_mant;
            out_data_d.fraction_digits   = job_q.flush_frac;
            out_data_d.overflow          = job_q.flush_ovf;
            out_data_d.unterminated      = job_q.flush_unt;
            job_d.flush_valid            = 1'b0;
            state_d = job_q.single_valid ? ST_ISSUE : ST_IDLE;
          end
        end else if (job_q.single_valid) begin
          if (can_load) begin
            out_valid_d           = 1'b1;
            out_data_d            = '0;
            out_data_d.token_kind = job_q.single_kind;
            out_data_d.text_byte  = job_q.single_byte;
            out_data_d.run_last   = 1'b1;
            job_d.single_valid    = 1'b0;
            state_d               = ST_IDLE;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_FETCH: begin
        // read data is in; keyword match runs along the text
        if (can_load) begin
          out_valid_d              = 1'b1;
          out_data_d               = '0;
          out_data_d.token_kind    = job_q.flush_kind;
          out_data_d.text_byte     = rd_data_q;
          out_data_d.text_index    = idx_ext;
          out_data_d.token_length  = job_q.flush_len;
          out_data_d.run_last      = last;
          out_data_d.is_uniform    = last && (job_q.flush_kind == sst_pkg::KIND_NAME) &&
                                     (job_q.flush_len == sst_pkg::KW_UNIFORM_LEN) &&
                                     kw_uni_q && u_hit;
          out_data_d.is_in         = last && (job_q.flush_kind == sst_pkg::KIND_NAME) &&
                                     (job_q.flush_len == sst_pkg::KW_IN_LEN) &&
                                     kw_in_q && i_hit;
          out_data_d.overflow      = job_q.flush_ovf;
          out_data_d.unterminated  = job_q.flush_unt;
          kw_uni_d                 = kw_uni_q && u_hit;
          kw_in_d                  = kw_in_q && i_hit;
          if (last) begin
            job_d.flush_valid = 1'b0;
            state_d = job_q.single_valid ? ST_ISSUE : ST_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_ISSUE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      job_q       <= '0;
      idx_q       <= '0;
      kw_uni_q    <= 1'b0;
      kw_in_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      job_q       <= job_d;
      idx_q       <= idx_d;
      kw_uni_q    <= kw_uni_d;
      kw_in_q     <= kw_in_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  assign ready_o     = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ rtl/shader_source_tokenizer.sv @@
// ----------------------------------------------------------------------------
// shader_source_tokenizer
// Streaming lexer for shader source text: one byte per input word, token
// result words out, one per stored text byte or per token without text.
// ----------------------------------------------------------------------------
// A byte that continues a token, starts one or is skipped leaves the input
// ready for the next byte. A token that ends is then walked out of the text
// memory, read through a registered port: a name or string one stored byte
// after another, each read then loaded as a result word, and a literal,
// bracket, error or end token as a single word, flush token first. Input is
// held off until the last word of the item is in the output register, so
// output stalls hold it off too; that word may still wait there while the
// next byte is taken. At most min(TEXT_CAPACITY, 32) text bytes are kept per
// token. The text memory needs no clearing after reset.
module shader_source_tokenizer #(
  parameter int TEXT_CAPACITY = sst_pkg::TEXT_CAPACITY_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sst_in_if.sink    in_i,
  sst_out_if.source out_o
);

  localparam int STORE_LIMIT = (TEXT_CAPACITY < sst_pkg::TEXT_LIMIT) ?
                               TEXT_CAPACITY : sst_pkg::TEXT_LIMIT;
  localparam int AW = $clog2(STORE_LIMIT);

  logic               in_fire;
  logic               ready;
  sst_pkg::cmd_t      cmd;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [7:0]         wr_data;
  logic               scan_idle;
  logic               out_valid;
  sst_pkg::out_word_t out_data;

  assign in_fire = in_i.valid && ready;

  // Token scanner
  sst_scan #(
    .TEXT_CAPACITY (TEXT_CAPACITY)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_fire),
    .word_i      (in_i.data),
    .cmd_o       (cmd),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .scan_idle_o (scan_idle)
  );

  // Text memory and result sequencer
  sst_emit #(
    .TEXT_CAPACITY (TEXT_CAPACITY)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_fire),
    .cmd_i       (cmd),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .ready_o     (ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_data)
  );

  assign in_i.ready  = ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_data;

  // End of input always leaves the scanner between tokens
  a_eoi_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.data.end_of_input |=> scan_idle)
    else $error("scanner not idle after end of input");

  // Text is written only on an accepted word, never during emission
  a_wr_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> in_fire)
    else $error("text write without accepted word");

  // A new result word follows from emission work, not from an idle cycle
  a_out_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(!in_i.ready))
    else $error("result word appeared while input side was idle");

endmodule
